/* rtl/core/wsp_pkg.sv */
package wsp_pkg;

    localparam int TIME_W    = 32;
    localparam int CONST_W   = 32;
    localparam int SPEED_W   = 24;
    localparam int FRAC_BITS = 8;
    localparam int DIV_STEPS = CONST_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CONST_W-1:0] FRONT_CONST_RST = CONST_W'(72546458);
    localparam logic [CONST_W-1:0] REAR_CONST_RST  = CONST_W'(233736448);
    localparam logic [SPEED_W-1:0] SPEED_MAX       = '1;

    // register indexes on the configuration port
    localparam logic REG_FRONT_CONST = 1'b0;
    localparam logic REG_REAR_CONST  = 1'b1;

    // input kinds
    localparam logic ACT_PULSE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

endpackage

/* rtl/core/wsp_div.sv */
module wsp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wsp_pkg::CONST_W-1:0] dividend,
    input  logic [wsp_pkg::CONST_W-1:0] divisor,
    output logic                        done,
    output logic [wsp_pkg::CONST_W-1:0] quotient
);
    import wsp_pkg::*;

    // restoring radix-2 divider, one quotient bit per cycle
    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CONST_W-1:0]   rem_reg;
    logic [CONST_W-1:0]   quo_reg;
    logic [CONST_W-1:0]   dsr_reg;

    logic [CONST_W:0]     rem_shift;
    logic [CONST_W:0]     diff;
    logic                 fits;

    assign rem_shift = {rem_reg, quo_reg[CONST_W-1]};
    assign diff      = rem_shift - {1'b0, dsr_reg};
    assign fits      = !diff[CONST_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[CONST_W-1:0] : rem_shift[CONST_W-1:0];
            quo_reg <= {quo_reg[CONST_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/wheel_speed_from_pulse_period.sv */
// Wheel speed from magnet pulse period. A pulse request (tuser[0] = 0) stores the wrapping
// time since the previous pulse as the period; it gives no result. A query request
// (tuser[0] = 1, tuser[1] picks the front constant) returns constant / period in 1/256 MPH,
// saturated to 24 bits, or zero with the stopped flag when no period is held or the time
// since the last pulse reaches constant >> 8. A query that runs the divider passes through
// the check state, 32 steps of the restoring divider, the capture of the quotient and the
// hand-over to the output register, which waits until the output is free; a stopped query
// skips the divider. The input opens again with the hand-over. One request is worked on at
// a time; the result register lets the next request in while a result waits downstream. The
// user writes constants through the cfg port only while idle; the block does not enforce it.
module wheel_speed_from_pulse_period (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic                        cfg_addr,
    input  logic [wsp_pkg::CONST_W-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] time_us
    input  logic [1:0]                  s_tuser,   // [0] action, [1] front_wheel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // [23:0] speed_q8
    output logic                        m_tuser    // [0] stopped
);
    import wsp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [CONST_W-1:0]   front_const_reg;
    logic [CONST_W-1:0]   rear_const_reg;
    logic [TIME_W-1:0]    last_pulse_reg;
    logic [TIME_W-1:0]    period_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [CONST_W-1:0]   k_reg;
    logic [SPEED_W-1:0]   res_speed_reg;
    logic                 res_stop_reg;
    logic                 m_tvalid_reg;
    logic [SPEED_W-1:0]   m_speed_reg;
    logic                 m_stop_reg;

    logic                 in_acc;
    logic [TIME_W-1:0]    since;
    logic                 stall;
    logic                 div_start;
    logic                 div_done;
    logic [CONST_W-1:0]   div_quo;
    logic [SPEED_W-1:0]   quo_sat;
    logic                 out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign since     = time_reg - last_pulse_reg;
    assign stall     = (period_reg == '0) || (since >= (k_reg >> FRAC_BITS));
    assign div_start = (state_reg == ST_CHECK) && !stall;
    assign quo_sat   = (div_quo[CONST_W-1:SPEED_W] != '0) ? SPEED_MAX
                                                           : div_quo[SPEED_W-1:0];

    wsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (k_reg),
        .divisor  (period_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_const_reg <= FRONT_CONST_RST;
            rear_const_reg  <= REAR_CONST_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_FRONT_CONST: front_const_reg <= cfg_wdata;
                REG_REAR_CONST:  rear_const_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pulse_reg <= '0;
            period_reg     <= '0;
        end
        else if (in_acc && (s_tuser[0] == ACT_PULSE))
        begin
            period_reg     <= s_tdata - last_pulse_reg;
            last_pulse_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            time_reg <= s_tdata;
            k_reg    <= s_tuser[1] ? front_const_reg : rear_const_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            m_speed_reg   <= '0;
            m_stop_reg    <= 1'b0;
            res_speed_reg <= '0;
            res_stop_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (s_tuser[0] == ACT_QUERY))
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (stall)
                    begin
                        res_speed_reg <= '0;
                        res_stop_reg  <= 1'b1;
                        state_reg     <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        res_speed_reg <= quo_sat;
                        res_stop_reg  <= 1'b0;
                        state_reg     <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_speed_reg  <= res_speed_reg;
                        m_stop_reg   <= res_stop_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_speed_reg;
    assign m_tuser  = m_stop_reg;

`ifndef ASSERT_OFF
    // a query holds the input side closed while it is worked on
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser[0] == ACT_QUERY)) |=> !s_tready)
        else $error("input taken during a query");

    // divider result only arrives while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider done outside divide state");

    // a stopped result always carries zero speed
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_stop_reg) |-> (m_speed_reg == '0))
        else $error("stopped result with non-zero speed");
`endif

endmodule
